/* hdl/espc_pkg.sv */
`timescale 1ns / 1ps

package espc_pkg;

	// Field widths
	localparam int POS_W  = 16;
	localparam int CFG_W  = 24;
	localparam int FS_W   = 15;
	localparam int PG_W   = 16;
	localparam int IG_W   = 24;
	localparam int TGT_W  = 18;
	localparam int PWR_W  = 16;
	localparam int IDX_W  = 2;

	// Ramp divider: magnitude of the ramp numerator, scaled by 2048
	localparam int MAG_W  = 17;
	localparam int FRAC_W = 11;
	localparam int DIV_W  = MAG_W + FRAC_W;

	// Default window length
	localparam int WINDOW_LEN_DEF = 200;

	// Register reset values
	localparam logic [FS_W-1:0] FS_RESET  = 15'd3359;
	localparam logic [FS_W-1:0] TOL_RESET = 15'd164;
	localparam logic [PG_W-1:0] PG_RESET  = 16'd32768;
	localparam logic [IG_W-1:0] IG_RESET  = 24'd8389;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_FLOOR_SPACING   = 2'd0;
	localparam logic [IDX_W-1:0] REG_FLOOR_TOLERANCE = 2'd1;
	localparam logic [IDX_W-1:0] REG_PROP_GAIN       = 2'd2;
	localparam logic [IDX_W-1:0] REG_INTEGRAL_GAIN   = 2'd3;

	// Fixed-point limits
	localparam int ONE_Q10  = 1024;
	localparam int TGT_MAX  = 131071;
	localparam int TGT_MIN  = -131072;
	localparam int PWR_MAX  = 16384;
	localparam int RND_BIT  = 19;
	localparam int PWR_SHR  = 20;

	// Divider request and response
	typedef struct packed {
		logic             start;
		logic             neg;
		logic [MAG_W-1:0] mag;
		logic [FS_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic                    busy;
		logic                    done;
		logic signed [TGT_W-1:0] quot;
	} div_rsp_t;

endpackage

/* hdl/espc_ram.sv */
`timescale 1ns / 1ps

module espc_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 200
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/espc_div.sv */
`timescale 1ns / 1ps

module espc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  espc_pkg::div_req_t req,
	output espc_pkg::div_rsp_t rsp
);
	import espc_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [FS_W-1:0]  den_q;
	logic             neg_q;
	logic [FS_W-1:0]  rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [FS_W:0]    shifted;
	logic             fits;
	logic [FS_W:0]    diff;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		shifted = {rem_q, quo_q[DIV_W-1]};
		fits    = shifted >= {1'b0, den_q};
		diff    = shifted - {1'b0, den_q};
	end

	// Sequence the steps, one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			den_q  <= '0;
			neg_q  <= 1'b0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				den_q  <= (req.den == '0) ? FS_W'(1) : req.den;
				neg_q  <= req.neg;
				rem_q  <= '0;
				quo_q  <= {req.mag, {FRAC_W{1'b0}}};
				cnt_q  <= CNT_W'(DIV_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? diff[FS_W-1:0] : shifted[FS_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], fits};
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Apply the sign and saturate to the target range
	always_comb begin
		rsp.busy = busy_q;
		rsp.done = done_q;
		if (neg_q) begin
			if (quo_q > DIV_W'(-TGT_MIN)) begin
				rsp.quot = TGT_W'(TGT_MIN);
			end else begin
				rsp.quot = TGT_W'(0) - quo_q[TGT_W-1:0];
			end
		end else begin
			if (quo_q > DIV_W'(TGT_MAX)) begin
				rsp.quot = TGT_W'(TGT_MAX);
			end else begin
				rsp.quot = quo_q[TGT_W-1:0];
			end
		end
	end

endmodule

/* hdl/elevator_speed_profile_pi_control_top.sv */
`timescale 1ns / 1ps
// A request taken in idle passes the decide, error, proportional and integral multiply,
// sum and finish states; a ramp target adds a divide state for the bit-serial divider
// (28 quotient bits, one a cycle). A new request is taken only after the last result is
// registered; one shared multiplier forms the proportional and integral products in turn.
// Reset: asynchronous, active low; registers return to defaults, window reads as zero
// until each slot is written (fill flag), no clearing pass.
module elevator_speed_profile_pi_control_top #(
	parameter int WINDOW_LEN = espc_pkg::WINDOW_LEN_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [espc_pkg::POS_W-1:0]  car_position,
	input  logic signed [espc_pkg::POS_W-1:0]  car_velocity,
	input  logic                               up_call_pressed,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [espc_pkg::PWR_W-1:0]  motor_power,
	output logic                               brake_on,
	output logic                               clear_up_call,
	output logic                               change_loading,
	input  logic                               cfg_we,
	input  logic [espc_pkg::IDX_W-1:0]         cfg_index,
	input  logic [espc_pkg::CFG_W-1:0]         cfg_data
);
	import espc_pkg::*;

	localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int SUM_W  = TGT_W + $clog2(WINDOW_LEN + 1);
	localparam int MA_W   = IG_W + 1;
	localparam int MUL_W  = MA_W + SUM_W;
	localparam int ACC_W  = MUL_W + 1;
	localparam int CMP_W  = 19;

	localparam logic signed [ACC_W-1:0] PMAX_A = ACC_W'(PWR_MAX);
	localparam logic signed [ACC_W-1:0] PMIN_A = -ACC_W'(PWR_MAX);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_DIV,
		ST_ERR,
		ST_MULP,
		ST_MULI,
		ST_SUM,
		ST_FIN
	} state_t;

	state_t state_q;

	// Configuration
	logic [FS_W-1:0] fs_q;
	logic [FS_W-1:0] tol_q;
	logic [PG_W-1:0] pg_q;
	logic [IG_W-1:0] ig_q;

	// Controller state
	logic                    heading_q;
	logic                    brake_q;
	logic signed [TGT_W-1:0] target_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SLOT_W-1:0]       slot_q;
	logic                    full_q;

	// Per-request working registers
	logic signed [POS_W-1:0] pos_q;
	logic signed [POS_W-1:0] vel_q;
	logic                    call_q;
	logic                    loading_q;
	logic signed [TGT_W-1:0] old_q;
	logic signed [TGT_W-1:0] err_q;
	logic signed [MUL_W-1:0] prod_q;
	logic signed [ACC_W-1:0] acc_q;

	// Result register
	logic                    out_valid_q;
	logic signed [PWR_W-1:0] power_q;
	logic                    brake_out_q;
	logic                    clear_q;
	logic                    change_q;

	// Decision logic
	logic signed [CMP_W-1:0] pos_x, fs_x, tol_x, m_val, m_abs;
	logic                    rev, h1, brake_set, up_ramp, dn_ramp;

	// Error and sum
	logic signed [CMP_W-1:0] err_diff;
	logic signed [TGT_W-1:0] err_c;
	logic signed [SUM_W-1:0] sum_next;

	// Shared multiplier
	logic signed [MA_W-1:0]  mul_a;
	logic signed [SUM_W-1:0] mul_b;
	logic signed [MUL_W-1:0] mul_p;

	// Output rounding
	logic signed [ACC_W-1:0] rnd;
	logic signed [ACC_W-1:0] shr;
	logic signed [PWR_W-1:0] pwr_c;

	// Window memory
	logic              ram_re;
	logic              ram_we;
	logic [TGT_W-1:0]  ram_rdata;

	espc_pkg::div_req_t div_req;
	espc_pkg::div_rsp_t div_rsp;

	// Direction, brake and ramp decisions for the held sample
	always_comb begin
		pos_x     = {{(CMP_W - POS_W){pos_q[POS_W-1]}}, pos_q};
		fs_x      = {{(CMP_W - FS_W){1'b0}}, fs_q};
		tol_x     = {{(CMP_W - FS_W){1'b0}}, tol_q};
		rev       = heading_q && (pos_x > ((fs_x <<< 1) + tol_x));
		h1        = heading_q && !rev;
		brake_set = !h1 && (pos_x < tol_x);
		up_ramp   = h1 && ((pos_x <<< 1) > (fs_x + (fs_x <<< 1)));
		dn_ramp   = !h1 && ((pos_x <<< 1) < fs_x);
		m_val     = up_ramp ? ((fs_x <<< 1) - pos_x) : (CMP_W'(0) - pos_x);
		m_abs     = m_val[CMP_W-1] ? (CMP_W'(0) - m_val) : m_val;
	end

	// Start the ramp division
	always_comb begin
		div_req.start = (state_q == ST_DECIDE) && !call_q && (up_ramp || dn_ramp);
		div_req.neg   = m_val[CMP_W-1];
		div_req.mag   = m_abs[MAG_W-1:0];
		div_req.den   = fs_q;
	end

	espc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// Saturated speed error and updated window sum
	always_comb begin
		err_diff = {{(CMP_W - TGT_W){target_q[TGT_W-1]}}, target_q}
		         - {{(CMP_W - POS_W){vel_q[POS_W-1]}}, vel_q};
		if (err_diff > CMP_W'(TGT_MAX)) begin
			err_c = TGT_W'(TGT_MAX);
		end else if (err_diff < $signed(CMP_W'(TGT_MIN))) begin
			err_c = TGT_W'(TGT_MIN);
		end else begin
			err_c = err_diff[TGT_W-1:0];
		end
		sum_next = sum_q
		         - {{(SUM_W - TGT_W){old_q[TGT_W-1]}}, old_q}
		         + {{(SUM_W - TGT_W){err_c[TGT_W-1]}}, err_c};
	end

	// Select operands for the one multiplier
	always_comb begin
		if (state_q == ST_MULI) begin
			mul_a = {1'b0, ig_q};
			mul_b = sum_q;
		end else begin
			mul_a = {{(MA_W - PG_W){1'b0}}, pg_q};
			mul_b = {{(SUM_W - TGT_W){err_q[TGT_W-1]}}, err_q};
		end
		mul_p = mul_a * mul_b;
	end

	// Round to Q1.14 and saturate
	always_comb begin
		rnd = acc_q + ACC_W'(1 << RND_BIT);
		shr = rnd >>> PWR_SHR;
		if (shr > PMAX_A) begin
			pwr_c = PWR_W'(PWR_MAX);
		end else if (shr < PMIN_A) begin
			pwr_c = PWR_W'(-PWR_MAX);
		end else begin
			pwr_c = shr[PWR_W-1:0];
		end
	end

	assign ram_re = (state_q == ST_IDLE) && in_valid;
	assign ram_we = (state_q == ST_ERR);

	espc_ram #(
		.WIDTH(TGT_W),
		.DEPTH(WINDOW_LEN)
	) u_window (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_q),
		.wdata(err_c),
		.re   (ram_re),
		.raddr(slot_q),
		.rdata(ram_rdata)
	);

	// Sequencer, controller state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fs_q        <= FS_RESET;
			tol_q       <= TOL_RESET;
			pg_q        <= PG_RESET;
			ig_q        <= IG_RESET;
			heading_q   <= 1'b1;
			brake_q     <= 1'b0;
			target_q    <= TGT_W'(ONE_Q10);
			sum_q       <= '0;
			slot_q      <= '0;
			full_q      <= 1'b0;
			pos_q       <= '0;
			vel_q       <= '0;
			call_q      <= 1'b0;
			loading_q   <= 1'b0;
			old_q       <= '0;
			err_q       <= '0;
			prod_q      <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			power_q     <= '0;
			brake_out_q <= 1'b0;
			clear_q     <= 1'b0;
			change_q    <= 1'b0;
		end else begin
			// Take configuration writes
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FLOOR_SPACING:   fs_q  <= cfg_data[FS_W-1:0];
					REG_FLOOR_TOLERANCE: tol_q <= cfg_data[FS_W-1:0];
					REG_PROP_GAIN:       pg_q  <= cfg_data[PG_W-1:0];
					REG_INTEGRAL_GAIN:   ig_q  <= cfg_data[IG_W-1:0];
					default: ;
				endcase
			end

			// Drop the result once taken, unless a new one replaces it
			if (out_valid_q && out_ready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						pos_q   <= car_position;
						vel_q   <= car_velocity;
						call_q  <= up_call_pressed;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					old_q <= full_q ? $signed(ram_rdata) : '0;
					if (call_q) begin
						heading_q <= 1'b1;
						brake_q   <= 1'b0;
						loading_q <= 1'b1;
						target_q  <= TGT_W'(ONE_Q10);
						state_q   <= ST_ERR;
					end else begin
						heading_q <= h1;
						loading_q <= rev;
						if (brake_set) begin
							brake_q <= 1'b1;
						end
						if (up_ramp || dn_ramp) begin
							state_q <= ST_DIV;
						end else begin
							if (rev) begin
								target_q <= TGT_W'(-ONE_Q10);
							end
							state_q <= ST_ERR;
						end
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						target_q <= div_rsp.quot;
						state_q  <= ST_ERR;
					end
				end
				ST_ERR: begin
					err_q <= err_c;
					sum_q <= sum_next;
					if (slot_q == SLOT_W'(WINDOW_LEN - 1)) begin
						slot_q <= '0;
						full_q <= 1'b1;
					end else begin
						slot_q <= slot_q + SLOT_W'(1);
					end
					state_q <= ST_MULP;
				end
				ST_MULP: begin
					prod_q  <= mul_p;
					state_q <= ST_MULI;
				end
				ST_MULI: begin
					acc_q   <= {prod_q[MUL_W-1], prod_q} <<< 8;
					prod_q  <= mul_p;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					acc_q   <= acc_q + {prod_q[MUL_W-1], prod_q};
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					// Hold until the result register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						power_q     <= pwr_c;
						brake_out_q <= brake_q;
						clear_q     <= call_q;
						change_q    <= loading_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready       = (state_q == ST_IDLE);
	assign out_valid      = out_valid_q;
	assign motor_power    = power_q;
	assign brake_on       = brake_out_q;
	assign clear_up_call  = clear_q;
	assign change_loading = change_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while a request is in progress");

	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |=> full_q)
		else $error("window fill flag dropped");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q < WINDOW_LEN)
		else $error("window slot out of range");

	a_power_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (motor_power <= 16'sd16384 && motor_power >= -16'sd16384))
		else $error("motor power beyond saturation limits");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> (state_q == ST_DIV))
		else $error("divider running outside the divide state");
`endif

endmodule
